// ----- design/nhp_pkg.sv -----
// ----------------------------------------------------------------------------
// nhp_pkg
// shared codes, widths and types of the weighted neighbor hop picker
// ----------------------------------------------------------------------------
package nhp_pkg;

  localparam int ID_W     = 20;
  localparam int RATE_W   = 32;
  localparam int FRAC_W   = 24;
  localparam int SUM_W    = 48;
  localparam int TGT_W    = 64;
  localparam int ENTRY_W  = ID_W + RATE_W;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 136;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_PICK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- design/nhp_ram.sv -----
// ----------------------------------------------------------------------------
// nhp_ram
// neighbor table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module nhp_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [nhp_pkg::ENTRY_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [nhp_pkg::ENTRY_W-1:0] rdata
);

  logic [nhp_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/nhp_div.sv -----
// ----------------------------------------------------------------------------
// nhp_div
// bit-serial reciprocal, floor(2^32 / divisor), saturated to 32 bits
// ----------------------------------------------------------------------------
module nhp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  nhp_pkg::div_req_t          req,
  output logic                       done,
  output logic [nhp_pkg::RATE_W-1:0] quotient
);

  logic                       busy;
  logic                       sat;
  logic [5:0]                 cnt;
  logic [nhp_pkg::SUM_W-1:0]  d;
  logic [nhp_pkg::SUM_W-1:0]  rem;
  logic [nhp_pkg::RATE_W-1:0] q;
  logic [nhp_pkg::SUM_W:0]    rem_s;
  logic                       ge;

  assign rem_s = {rem, (cnt == 6'd32)};
  assign ge    = rem_s >= {1'b0, d};
  assign quotient = sat ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      sat  <= 1'b0;
    end else if (req.start) begin
      d   <= req.divisor;
      rem <= '0;
      q   <= '0;
      cnt <= 6'd32;
      if (req.divisor <= nhp_pkg::SUM_W'(1)) begin
        sat  <= 1'b1;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        sat  <= 1'b0;
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else if (busy) begin
      if (ge) begin
        rem <= nhp_pkg::SUM_W'(rem_s - {1'b0, d});
        q   <= {q[nhp_pkg::RATE_W-2:0], 1'b1};
      end else begin
        rem <= rem_s[nhp_pkg::SUM_W-1:0];
        q   <= {q[nhp_pkg::RATE_W-2:0], 1'b0};
      end
      if (cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end

endmodule

// ----- design/weighted_neighbor_hop_picker_top.sv -----
// ----------------------------------------------------------------------------
// weighted_neighbor_hop_picker_top
// sorted neighbor rate table with roulette wheel pick and rate summary
// ----------------------------------------------------------------------------
// flow: a set searches the sorted table and shifts entries up to insert, a pick walks
//   entries until the running sum passes the target, then the summary stage runs the
//   fastest rate scan beside the 33-step reciprocal, which saturates when the total is 0 or 1
// throughput: one item at a time, the next transfer is accepted the cycle after
//   the result enters the output register, which waits while an earlier result stalls
// reset: synchronous, empties the table and drops any pending result
module weighted_neighbor_hop_picker_top #(
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // neighbor_id, hop_rate, random_fraction
  input  logic [nhp_pkg::S_DATA_W-1:0]   s_tdata,
  // opcode
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // picked_id, pick_found, total_rate, fastest_rate, escape_time, status
  output logic [nhp_pkg::M_DATA_W-1:0]   m_tdata
);

  localparam int AW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEIGHBORS);

  localparam logic [3:0] IDLE    = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EV    = 4'd2;
  localparam logic [3:0] SH_RD   = 4'd3;
  localparam logic [3:0] SH_WR   = 4'd4;
  localparam logic [3:0] INS     = 4'd5;
  localparam logic [3:0] P_M1    = 4'd6;
  localparam logic [3:0] P_M2    = 4'd7;
  localparam logic [3:0] P_M3    = 4'd8;
  localparam logic [3:0] P_RD    = 4'd9;
  localparam logic [3:0] P_EV    = 4'd10;
  localparam logic [3:0] F_START = 4'd11;
  localparam logic [3:0] F_RD    = 4'd12;
  localparam logic [3:0] F_EV    = 4'd13;
  localparam logic [3:0] WAIT    = 4'd14;
  localparam logic [3:0] DONE    = 4'd15;

  logic [3:0]                  state;
  logic [CNT_W-1:0]            count;
  logic [nhp_pkg::SUM_W-1:0]   sum;
  logic [CNT_W-1:0]            i;
  logic [CNT_W-1:0]            j;
  logic [CNT_W-1:0]            pos;
  logic [1:0]                  op;
  logic [nhp_pkg::ID_W-1:0]    id;
  logic [nhp_pkg::RATE_W-1:0]  rate;
  logic [nhp_pkg::FRAC_W-1:0]  frac;
  logic [47:0]                 prod_lo;
  logic [47:0]                 prod_hi;
  logic [nhp_pkg::TGT_W-1:0]   target;
  logic [nhp_pkg::SUM_W-1:0]   run;
  logic [nhp_pkg::RATE_W-1:0]  best;
  logic [nhp_pkg::ID_W-1:0]    picked;
  logic                        found;
  logic [1:0]                  status;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [nhp_pkg::ENTRY_W-1:0] wdata;
  logic [AW-1:0]               raddr;
  logic [nhp_pkg::ENTRY_W-1:0] rdata;
  logic [nhp_pkg::ID_W-1:0]    rd_id;
  logic [nhp_pkg::RATE_W-1:0]  rd_rate;
  logic [CNT_W-1:0]            j_m1;
  logic [nhp_pkg::SUM_W-1:0]   run_next;
  logic [nhp_pkg::TGT_W-1:0]   run_sh;

  nhp_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [nhp_pkg::RATE_W-1:0]  div_q;

  assign rd_id    = rdata[nhp_pkg::ENTRY_W-1:nhp_pkg::RATE_W];
  assign rd_rate  = rdata[nhp_pkg::RATE_W-1:0];
  assign j_m1     = j - CNT_W'(1);
  assign run_next = run + nhp_pkg::SUM_W'(rd_rate);
  assign run_sh   = {run_next[39:0], 24'd0};
  assign s_tready = (state == IDLE);

  assign div_req.start   = (state == F_START);
  assign div_req.divisor = sum;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = {id, rate};
    raddr = i[AW-1:0];
    case (state)
      S_EV: begin
        if (rd_id == id) begin
          we    = 1'b1;
          waddr = i[AW-1:0];
        end
      end
      SH_RD: raddr = j_m1[AW-1:0];
      SH_WR: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = rdata;
      end
      INS: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
      end
      default: ;
    endcase
  end

  nhp_ram #(
    .DEPTH  (MAX_NEIGHBORS),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  nhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            id     <= s_tdata[19:0];
            rate   <= s_tdata[51:20];
            frac   <= s_tdata[75:52];
            picked <= '0;
            found  <= 1'b0;
            status <= nhp_pkg::ST_OK;
            i      <= '0;
            run    <= '0;
            case (s_tuser)
              nhp_pkg::OP_SET: begin
                if (s_tdata[51:20] == '0) begin
                  status <= nhp_pkg::ST_ZERO;
                  state  <= F_START;
                end else begin
                  state <= S_RD;
                end
              end
              nhp_pkg::OP_PICK: begin
                if (count == '0) begin
                  status <= nhp_pkg::ST_EMPTY;
                  state  <= F_START;
                end else begin
                  state <= P_M1;
                end
              end
              nhp_pkg::OP_CLEAR: begin
                count <= '0;
                sum   <= '0;
                state <= F_START;
              end
              default: state <= F_START;
            endcase
          end
        end
        S_RD: begin
          if (i == count) begin
            pos <= i;
            j   <= count;
            if (count == CNT_MAX) begin
              status <= nhp_pkg::ST_FULL;
              state  <= F_START;
            end else if (count > i) begin
              state <= SH_RD;
            end else begin
              state <= INS;
            end
          end else begin
            state <= S_EV;
          end
        end
        S_EV: begin
          if (rd_id < id) begin
            i     <= i + CNT_W'(1);
            state <= S_RD;
          end else if (rd_id == id) begin
            sum   <= sum - nhp_pkg::SUM_W'(rd_rate) + nhp_pkg::SUM_W'(rate);
            state <= F_START;
          end else begin
            pos <= i;
            j   <= count;
            if (count == CNT_MAX) begin
              status <= nhp_pkg::ST_FULL;
              state  <= F_START;
            end else begin
              state <= SH_RD;
            end
          end
        end
        SH_RD: state <= SH_WR;
        SH_WR: begin
          j     <= j_m1;
          state <= (j_m1 > pos) ? SH_RD : INS;
        end
        INS: begin
          count <= count + CNT_W'(1);
          sum   <= sum + nhp_pkg::SUM_W'(rate);
          state <= F_START;
        end
        P_M1: begin
          prod_lo <= frac * sum[23:0];
          state   <= P_M2;
        end
        P_M2: begin
          prod_hi <= frac * sum[47:24];
          state   <= P_M3;
        end
        P_M3: begin
          target <= {16'd0, prod_lo} + {prod_hi[39:0], 24'd0};
          state  <= P_RD;
        end
        P_RD: begin
          if (i == count) begin
            status <= nhp_pkg::ST_EMPTY;
            state  <= F_START;
          end else begin
            state <= P_EV;
          end
        end
        P_EV: begin
          run <= run_next;
          if (run_sh > target) begin
            picked <= rd_id;
            found  <= 1'b1;
            state  <= F_START;
          end else begin
            i     <= i + CNT_W'(1);
            state <= P_RD;
          end
        end
        F_START: begin
          i     <= '0;
          best  <= '0;
          state <= F_RD;
        end
        F_RD: state <= (i == count) ? WAIT : F_EV;
        F_EV: begin
          if (rd_rate > best) begin
            best <= rd_rate;
          end
          i     <= i + CNT_W'(1);
          state <= F_RD;
        end
        WAIT: begin
          if (div_done) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, status, div_q, best, sum, found, picked};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX) else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == DONE) && m_tvalid && !m_tready |=> state == DONE)
    else $error("result dropped while output stalled");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> m_tdata[134:133] == nhp_pkg::ST_OK)
    else $error("pick found with error status");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives set, pick, clear and unused commands into the neighbor hop picker and
// checks every result field against a sorted rate table kept alongside
// ----------------------------------------------------------------------------

class hop_table_scoreboard;
  logic [nhp_pkg::ID_W-1:0]   ids[16];
  logic [nhp_pkg::RATE_W-1:0] rates[16];
  int unsigned                count;
  logic [nhp_pkg::SUM_W-1:0]  total;
  logic [nhp_pkg::M_DATA_W-1:0] pending[$];
  int unsigned                errors;

  function void note_transfer(logic [1:0] op, logic [19:0] id, logic [31:0] rate,
                              logic [23:0] frac);
    logic [19:0] picked;
    logic        found;
    logic [1:0]  status;
    logic [63:0] target;
    logic [63:0] run;
    logic [31:0] best;
    logic [64:0] quot;
    logic [31:0] esc;
    logic [nhp_pkg::M_DATA_W-1:0] res;
    int unsigned pos;
    bit          done;
    picked = '0;
    found  = 1'b0;
    status = nhp_pkg::ST_OK;
    if (op == nhp_pkg::OP_SET) begin
      if (rate == 0) begin
        status = nhp_pkg::ST_ZERO;
      end else begin
        pos = 0;
        while (pos < count && ids[pos] < id) pos++;
        if (pos < count && ids[pos] == id) begin
          total = total - rates[pos] + rate;
          rates[pos] = rate;
        end else if (count >= 16) begin
          status = nhp_pkg::ST_FULL;
        end else begin
          for (int i = count; i > pos; i--) begin
            ids[i] = ids[i-1];
            rates[i] = rates[i-1];
          end
          ids[pos] = id;
          rates[pos] = rate;
          count++;
          total = total + rate;
        end
      end
    end else if (op == nhp_pkg::OP_PICK) begin
      if (count == 0) begin
        status = nhp_pkg::ST_EMPTY;
      end else begin
        target = 64'(frac) * 64'(total);
        run = '0;
        done = 0;
        for (int i = 0; i < count; i++) begin
          if (!done) begin
            run = run + 64'(rates[i]);
            if ((run << 24) > target) begin
              picked = ids[i];
              found = 1'b1;
              done = 1;
            end
          end
        end
        if (!found) status = nhp_pkg::ST_EMPTY;
      end
    end else if (op == nhp_pkg::OP_CLEAR) begin
      count = 0;
      total = '0;
    end
    best = '0;
    for (int i = 0; i < count; i++)
      if (rates[i] > best) best = rates[i];
    if (total == 0) begin
      esc = '1;
    end else begin
      quot = (65'd1 << 32) / 65'(total);
      esc = (quot > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
    end
    res = {1'b0, status, esc, best, total, found, picked};
    pending = {pending, res};
  endfunction

  function void check_result(logic [nhp_pkg::M_DATA_W-1:0] act);
    logic [nhp_pkg::M_DATA_W-1:0] exp;
    int lo[6];
    int wd[6];
    string nm[6];
    logic [nhp_pkg::M_DATA_W-1:0] e_f;
    logic [nhp_pkg::M_DATA_W-1:0] a_f;
    lo = '{0, 20, 21, 69, 101, 133};
    wd = '{20, 1, 48, 32, 32, 2};
    nm = '{"picked_id", "pick_found", "total_rate", "fastest_rate", "escape_time",
           "status"};
    if (pending.size() == 0) begin
      $display("%0t unexpected result %h", $time, act);
      errors++;
      return;
    end
    exp = pending.pop_front();
    for (int f = 0; f < 6; f++) begin
      e_f = (exp >> lo[f]) & ((136'd1 << wd[f]) - 1);
      a_f = (act >> lo[f]) & ((136'd1 << wd[f]) - 1);
      if (e_f !== a_f) begin
        $display("%0t %s expected %h actual %h", $time, nm[f], e_f, a_f);
        errors++;
      end
    end
  endfunction
endclass

module testbench;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [nhp_pkg::S_DATA_W-1:0] s_tdata;
  logic [1:0]                   s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [nhp_pkg::M_DATA_W-1:0] m_tdata;

  hop_table_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase = 0;
  logic        long_hold = 1'b0;
  int unsigned cycle_count = 0;
  logic [19:0] id_pool[20];

  weighted_neighbor_hop_picker_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (long_hold) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (phase == 1);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic send_cmd(logic [1:0] op, logic [19:0] id, logic [31:0] rate,
                          logic [23:0] frac);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'b0, frac, rate, id};
    do @(posedge clk); while (!s_tready);
    sb.note_transfer(op, id, rate, frac);
  endtask

  task automatic send_random;
    int unsigned r;
    logic [19:0] id;
    logic [31:0] rate;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 20'($urandom) : id_pool[$urandom_range(0, 19)];
    case ($urandom_range(0, 7))
      0: rate = '0;
      1, 2: rate = $urandom_range(1, 255);
      default: rate = $urandom;
    endcase
    if (r < 55) send_cmd(nhp_pkg::OP_SET, id, rate, 24'($urandom));
    else if (r < 93) send_cmd(nhp_pkg::OP_PICK, 20'($urandom), $urandom, 24'($urandom));
    else if (r < 97) send_cmd(nhp_pkg::OP_CLEAR, 20'($urandom), $urandom, 24'($urandom));
    else send_cmd(nhp_pkg::OP_UNUSED, 20'($urandom), $urandom, 24'($urandom));
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= nhp_pkg::OP_SET;
    foreach (id_pool[i]) id_pool[i] = 20'($urandom);
    id_pool[0] = 20'h0;
    id_pool[1] = 20'hFFFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_cmd(nhp_pkg::OP_PICK, 20'h0, 32'h0, 24'hFFFFFF);
    send_cmd(nhp_pkg::OP_SET, 20'h0, 32'h1, 24'h0);
    send_cmd(nhp_pkg::OP_SET, 20'hFFFFF, 32'hFFFFFFFF, 24'h0);
    send_cmd(nhp_pkg::OP_SET, 20'h12345, 32'h0, 24'h0);
    send_cmd(nhp_pkg::OP_SET, 20'h0, 32'h5, 24'h0);
    send_cmd(nhp_pkg::OP_PICK, 20'h0, 32'h0, 24'h0);
    send_cmd(nhp_pkg::OP_PICK, 20'hFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
    send_cmd(nhp_pkg::OP_UNUSED, 20'hFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
    send_cmd(nhp_pkg::OP_CLEAR, 20'h0, 32'h0, 24'h0);
    for (int i = 0; i < 17; i++)
      send_cmd(nhp_pkg::OP_SET, 20'(i * 3 + 1), 32'hFFFF_FFFF - i, 24'h0);
    send_cmd(nhp_pkg::OP_PICK, 20'h0, 32'h0, 24'h800000);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 65 : 32) : 0;
      recv_stall_pct = (ph == 2) ? 65 : ((ph == 3) ? 32 : 0);
      phase = ph;
      for (int n = 0; n < 230; n++) send_random();
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
